/* design/mbet_pkg.sv */
package mbet_pkg;

  localparam int Q_W       = 32;
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 12;
  localparam int COUNT_W   = 16;
  localparam int STEP_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_START        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP         = 3'd4;

  localparam logic [COUNT_W-1:0]   MAX_ITER_RST = 16'd256;
  localparam logic signed [Q_W-1:0] START_RST   = -32'sd536870912;
  localparam logic [STEP_W-1:0]    STEP_RST     = 31'd262144;

  // 4.0 in Q8.56.
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic load;
    logic c_add;
    logic z_mul;
    logic z_step;
    logic emit;
  } mbet_cmd_t;

  typedef struct packed {
    logic stop;
  } mbet_sts_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[Q_W-1:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/mbet_if.sv */
interface mbet_in_if;
  import mbet_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;
  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbet_out_if;
  import mbet_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;
  modport source (output valid, output iteration_count, input ready);
  modport sink (input valid, input iteration_count, output ready);
endinterface

/* design/mandelbrot_escape_time_unit.sv */
// Channel  Dir  Handshake            Word
// in_ch    in   valid/ready          pixel_col[11:0], pixel_row[11:0]
// out_ch   out  valid/ready          iteration_count[15:0]
// cfg      in   cfg_we (no stall)    cfg_index[2:0], cfg_wdata[31:0]
//
// One pixel at a time. In each iteration the three 32x32 products
// are registered, then the escape test, floor, add and saturate update z.
// A pixel occupies the unit from accept to the next in_ch.ready; while out_ch still
// holds an untaken word, the finished pixel waits in S_DONE.
// The output register holds one finished word, so the next pixel may run while it waits.
// Reset (synchronous, rst_n low) returns the registers to their defaults and empties out_ch.
module mandelbrot_escape_time_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  mbet_in_if.sink                         in_ch,
  mbet_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import mbet_pkg::*;

  logic [COUNT_W-1:0]    max_iterations_r;
  logic signed [Q_W-1:0] x_start_r, y_start_r;
  logic [STEP_W-1:0]     x_step_r, y_step_r;

  mbet_cmd_t cmd;
  mbet_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iterations_r <= MAX_ITER_RST;
      x_start_r        <= START_RST;
      x_step_r         <= STEP_RST;
      y_start_r        <= START_RST;
      y_step_r         <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITERATIONS: max_iterations_r <= cfg_wdata[COUNT_W-1:0];
        CFG_X_START:        x_start_r        <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_X_STEP:         x_step_r         <= cfg_wdata[STEP_W-1:0];
        CFG_Y_START:        y_start_r        <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_Y_STEP:         y_step_r         <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mbet_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .pixel_col       (in_ch.pixel_col),
    .pixel_row       (in_ch.pixel_row),
    .max_iterations  (max_iterations_r),
    .x_start         (x_start_r),
    .x_step          (x_step_r),
    .y_start         (y_start_r),
    .y_step          (y_step_r),
    .iteration_count (out_ch.iteration_count)
  );

endmodule

/* design/mbet_ctrl.sv */
module mbet_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mbet_pkg::mbet_cmd_t cmd,
  input  mbet_pkg::mbet_sts_t sts
);
  import mbet_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CADD = 3'd1;
  localparam logic [2:0] S_ZMUL = 3'd2;
  localparam logic [2:0] S_TEST = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CADD;
        end
      end
      S_CADD: begin
        cmd.c_add = 1'b1;
        state_nxt = S_ZMUL;
      end
      S_ZMUL: begin
        cmd.z_mul = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (sts.stop) begin
          state_nxt = S_DONE;
        end else begin
          cmd.z_step = 1'b1;
          state_nxt  = S_ZMUL;
        end
      end
      S_DONE: begin
        // The output register frees up in the same cycle its word is taken.
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after a word was taken");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result emitted but output not valid");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> state_r == S_DONE)
    else $error("finished result dropped while output stalled");

endmodule

/* design/mbet_datapath.sv */
module mbet_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbet_pkg::mbet_cmd_t           cmd,
  output mbet_pkg::mbet_sts_t           sts,
  input  logic [mbet_pkg::COORD_W-1:0]  pixel_col,
  input  logic [mbet_pkg::COORD_W-1:0]  pixel_row,
  input  logic [mbet_pkg::COUNT_W-1:0]  max_iterations,
  input  logic signed [mbet_pkg::Q_W-1:0] x_start,
  input  logic [mbet_pkg::STEP_W-1:0]   x_step,
  input  logic signed [mbet_pkg::Q_W-1:0] y_start,
  input  logic [mbet_pkg::STEP_W-1:0]   y_step,
  output logic [mbet_pkg::COUNT_W-1:0]  iteration_count
);
  import mbet_pkg::*;

  localparam int PROD_W = COORD_W + STEP_W;

  logic [PROD_W-1:0]     cprod_x_r, cprod_y_r;
  logic signed [Q_W-1:0] cx_r, cy_r, zx_r, zy_r;
  logic signed [63:0]    xx_r, yy_r, xy_r;
  logic [COUNT_W-1:0]    count_r, result_r;

  logic signed [63:0] cx_sum, cy_sum;
  logic signed [63:0] diff, diff_sh, xy_sh, nx_sum, ny_sum;
  logic [63:0]        mag;
  logic               escape;

  always_comb begin
    cx_sum  = x_start + $signed({{(64-PROD_W){1'b0}}, cprod_x_r});
    cy_sum  = y_start + $signed({{(64-PROD_W){1'b0}}, cprod_y_r});
    // Both squares are nonnegative, so their sum cannot wrap 64 bits.
    mag     = xx_r + yy_r;
    escape  = mag >= ESCAPE_LIMIT;
    diff    = xx_r - yy_r;
    // Arithmetic shifts give floor rounding; 2*zx*zy uses one bit less.
    diff_sh = diff >>> FRAC_BITS;
    xy_sh   = xy_r >>> (FRAC_BITS - 1);
    nx_sum  = diff_sh + cx_r;
    ny_sum  = xy_sh + cy_r;
    sts.stop = escape || (count_r >= max_iterations);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cprod_x_r <= pixel_col * x_step;
      cprod_y_r <= pixel_row * y_step;
    end
    if (cmd.c_add) begin
      cx_r    <= sat32(cx_sum);
      cy_r    <= sat32(cy_sum);
      zx_r    <= '0;
      zy_r    <= '0;
      count_r <= '0;
    end
    if (cmd.z_mul) begin
      xx_r <= zx_r * zx_r;
      yy_r <= zy_r * zy_r;
      xy_r <= zx_r * zy_r;
    end
    if (cmd.z_step) begin
      zx_r    <= sat32(nx_sum);
      zy_r    <= sat32(ny_sum);
      count_r <= count_r + 16'd1;
    end
    if (cmd.emit) begin
      result_r <= count_r;
    end
  end

  assign iteration_count = result_r;

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> count_r <= max_iterations)
    else $error("iteration count above the limit");

  a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.z_step |=> count_r == $past(count_r) + 16'd1)
    else $error("iteration step did not advance the count");

endmodule
